/* hw/rtl/rpnf_pkg.sv */
`timescale 1ns / 1ps

package rpnf_pkg;

  localparam int WORD_W    = 31;
  localparam int LEN_W     = 11;
  localparam int REM_W     = LEN_W + 1;
  localparam int DIV_CNT_W = $clog2(WORD_W);

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_COMP_RD,
    ST_COMP_WR,
    ST_DONE
  } rpnf_state_e;

endpackage

/* hw/rtl/rpnf_if.sv */
`timescale 1ns / 1ps

interface rpnf_in_if;
  import rpnf_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

interface rpnf_out_if;
  import rpnf_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] slot_number;
  logic             last_of_round;

  modport source (output valid, output slot_number, output last_of_round, input ready);
  modport sink   (input valid, input slot_number, input last_of_round, output ready);
endinterface

/* hw/rtl/random_permutation_next_free.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Payload
// in_i      in   valid/ready   random_word[30:0]
// out_o     out  valid/ready   slot_number[10:0], last_of_round
// cfg       in   cfg_we_i      cfg_wdata_i[10:0] (length_in_use)
//
// One item at a time. Each item is accepted, then divided by a restoring divider
// (one quotient bit per cycle), then walks the links past taken slots (one memory
// read per link), then, if it walked any, has its path rewritten (one entry per cycle).
// The first item of a round first sweeps the link memory, resetting its n entries.
// Reset is asynchronous, active low, and clears control state only.
// A finished item waits in ST_DONE while the output register is still held;
// the next item is taken while a finished item waits in the output register.

module random_permutation_next_free #(
  parameter int MAX_LENGTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rpnf_pkg::LEN_W-1:0] cfg_wdata_i,
  rpnf_in_if.sink                   in_i,
  rpnf_out_if.source                out_o
);
  import rpnf_pkg::*;

  localparam int IW = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1;
  localparam int WW = IW + REM_W;

  typedef struct packed {
    logic          taken;
    logic [IW-1:0] link;
  } entry_t;

  rpnf_state_e state_q, state_d;

  logic [LEN_W-1:0]     len_q;
  logic [LEN_W-1:0]     cnt_q, cnt_d;
  logic [LEN_W-1:0]     n_q, n_d;
  logic [WORD_W-1:0]    word_q, word_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] bit_q, bit_d;
  logic [IW-1:0]        start_q, start_d;
  logic [IW-1:0]        f_q, f_d;
  logic [IW-1:0]        v_q, v_d;
  logic [IW-1:0]        succ_q, succ_d;
  logic                 out_valid_q, out_valid_d;
  logic [LEN_W-1:0]     out_slot_q, out_slot_d;
  logic                 out_last_q, out_last_d;

  entry_t        mem [MAX_LENGTH];
  entry_t        rdata_q;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [IW-1:0] mem_raddr;

  logic [LEN_W-1:0] n_eff;
  logic [WW-1:0]    n_w;
  logic [WW-1:0]    nxt_w;
  logic [WW-1:0]    slot_w;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] rem_next;
  logic [LEN_W-1:0] cnt_inc;
  logic             last;

  always_comb begin
    if (cfg_wdata_i == '0 && len_q == '0) begin
      n_eff = LEN_W'(1);
    end else if (len_q == '0) begin
      n_eff = LEN_W'(1);
    end else if (32'(len_q) > 32'(MAX_LENGTH)) begin
      n_eff = LEN_W'(MAX_LENGTH);
    end else begin
      n_eff = len_q;
    end
  end

  assign n_w      = WW'(n_q);
  assign nxt_w    = WW'(v_q) + WW'(1);
  assign slot_w   = WW'(f_q) + WW'(1);
  assign trial    = {rem_q[REM_W-2:0], word_q[WORD_W-1]};
  assign rem_next = (trial >= REM_W'(n_q)) ? trial - REM_W'(n_q) : trial;
  assign cnt_inc  = cnt_q + LEN_W'(1);
  assign last     = (cnt_inc >= n_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    word_d      = word_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    start_d     = start_q;
    f_d         = f_q;
    v_d         = v_q;
    succ_d      = succ_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_slot_d  = out_slot_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_waddr   = v_q;
    mem_wdata   = '0;
    mem_raddr   = f_q;
    in_i.ready  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          word_d  = in_i.random_word;
          n_d     = n_eff;
          rem_d   = '0;
          bit_d   = DIV_CNT_W'(WORD_W - 1);
          v_d     = '0;
          state_d = (cnt_q == '0) ? ST_CLEAR : ST_DIV;
        end
      end
      ST_CLEAR: begin
        mem_we         = 1'b1;
        mem_waddr      = v_q;
        mem_wdata.taken = 1'b0;
        mem_wdata.link = (nxt_w < n_w) ? nxt_w[IW-1:0] : '0;
        if (nxt_w >= n_w) begin
          state_d = ST_DIV;
        end else begin
          v_d = nxt_w[IW-1:0];
        end
      end
      ST_DIV: begin
        rem_d  = rem_next;
        word_d = word_q << 1;
        bit_d  = bit_q - DIV_CNT_W'(1);
        if (bit_q == '0) begin
          start_d = IW'(rem_next);
          f_d     = IW'(rem_next);
          state_d = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        mem_raddr = f_q;
        state_d   = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (rdata_q.taken) begin
          f_d       = rdata_q.link;
          mem_raddr = rdata_q.link;
        end else begin
          mem_we          = 1'b1;
          mem_waddr       = f_q;
          mem_wdata.taken = 1'b1;
          mem_wdata.link  = rdata_q.link;
          succ_d          = rdata_q.link;
          v_d             = start_q;
          state_d         = (start_q == f_q) ? ST_DONE : ST_COMP_RD;
        end
      end
      ST_COMP_RD: begin
        mem_raddr = v_q;
        state_d   = ST_COMP_WR;
      end
      ST_COMP_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = v_q;
        mem_wdata.taken = rdata_q.taken;
        mem_wdata.link  = succ_q;
        v_d             = rdata_q.link;
        mem_raddr       = rdata_q.link;
        if (rdata_q.link == f_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_slot_d  = slot_w[LEN_W-1:0];
          out_last_d  = last;
          cnt_d       = last ? '0 : cnt_inc;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    word_q     <= word_d;
    rem_q      <= rem_d;
    bit_q      <= bit_d;
    start_q    <= start_d;
    f_q        <= f_d;
    v_q        <= v_d;
    succ_q     <= succ_d;
    out_slot_q <= out_slot_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.slot_number   = out_slot_q;
  assign out_o.last_of_round = out_last_q;

endmodule

/* hw/rtl/rpnf_checker.sv */
`timescale 1ns / 1ps

module rpnf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rpnf_pkg::LEN_W-1:0] out_slot_number_i,
  input logic                      out_last_of_round_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_slot_number_i) && $stable(out_last_of_round_i))
    else $error("result changed while stalled");

  // one item in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while busy");

  // no result right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("result appeared too early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_slot_number_i != '0)
    else $error("slot number zero");

endmodule

bind random_permutation_next_free rpnf_checker u_rpnf_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_slot_number_i   (out_o.slot_number),
  .out_last_of_round_i (out_o.last_of_round)
);

/* tb/tb_random_permutation_next_free.sv */
`timescale 1ns / 1ps

module tb_random_permutation_next_free;
  import rpnf_pkg::*;

  localparam int MAX_LEN     = 1024;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int RANDOM_ITEMS = 1100;

  typedef struct packed {
    logic [LEN_W-1:0] slot_number;
    logic             last_of_round;
  } slot_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  rpnf_in_if  word_bus ();
  rpnf_out_if slot_bus ();

  random_permutation_next_free #(
    .MAX_LENGTH(MAX_LEN)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (word_bus),
    .out_o      (slot_bus)
  );

  // predictor state
  logic [9:0]       link_tbl [MAX_LEN];
  bit               taken_tbl [MAX_LEN];
  int unsigned      round_fill;
  logic [LEN_W-1:0] length_reg;

  slot_result_t     pending_slots [$];
  int unsigned      errors;
  int unsigned      items_sent;
  int unsigned      cycle_count;
  bit               no_idle;
  bit               word_held;
  logic [WORD_W-1:0] prev_word;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned round_len(input logic [LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_LEN) return MAX_LEN;
    return len;
  endfunction

  function automatic int unsigned follow_link(input int unsigned s, input int unsigned n);
    int unsigned t;
    t = link_tbl[s % MAX_LEN];
    return (t < n) ? t : t % n;
  endfunction

  function automatic slot_result_t take_slot(input logic [WORD_W-1:0] word);
    int unsigned n, start, f, v, nx, succ, steps, i;
    slot_result_t r;
    n = round_len(length_reg);
    if (round_fill == 0) begin
      for (i = 0; i < MAX_LEN; i++) begin
        link_tbl[i]  = (i + 1 < n) ? 10'(i + 1) : 10'd0;
        taken_tbl[i] = 1'b0;
      end
    end
    start = word % n;
    f = start;
    for (steps = 0; steps < n && taken_tbl[f]; steps++)
      f = follow_link(f, n);
    taken_tbl[f] = 1'b1;
    // compress walked path onto the successor of the taken slot
    succ = follow_link(f, n);
    v = start;
    for (steps = 0; steps < n && v != f; steps++) begin
      nx = follow_link(v, n);
      link_tbl[v] = 10'(succ);
      v = nx;
    end
    round_fill++;
    r.last_of_round = (round_fill >= n);
    if (r.last_of_round) round_fill = 0;
    r.slot_number = LEN_W'(f + 1);
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic stop_input();
    if (word_held) begin
      word_bus.valid <= 1'b0;
      word_held = 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    stop_input();
    while (pending_slots.size() != 0) @(posedge clk);
  endtask

  task automatic send_word(input logic [WORD_W-1:0] word);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      if (word_held) word_bus.valid <= 1'b0;
      word_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_bus.valid       <= 1'b1;
    word_bus.random_word <= word;
    word_held = 1'b1;
    do @(posedge clk); while (!word_bus.ready);
    pending_slots.push_back(take_slot(word));
    prev_word = word;
    items_sent++;
  endtask

  task automatic write_length(input logic [LEN_W-1:0] value);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    length_reg = value;
    round_fill = 0;
  endtask

  function automatic logic [WORD_W-1:0] pick_word(input int unsigned n);
    int unsigned w;
    case ($urandom_range(0, 5))
      0, 1: w = $urandom;
      2: w = $urandom_range(0, 2 * n);
      3: w = 32'h7fff_ffff - $urandom_range(0, n);
      4: w = $urandom_range(0, 32'h7fff_ffff / n) * n;
      default: w = prev_word;
    endcase
    return WORD_W'(w);
  endfunction

  // reset length, top slot, wrap of the last link, collisions
  task automatic test_reset_length();
    send_word(31'd0);
    send_word(31'h7fff_ffff);
    send_word(31'd1024);
    send_word(31'h7fff_ffff);
    send_word(31'h4000_0000);
    send_word(31'd1023);
  endtask

  // one-element rounds; zero acts as one
  task automatic test_length_one();
    write_length(11'd1);
    send_word(31'd0);
    send_word(31'h7fff_ffff);
    send_word(31'h2aaa_aaaa);
    write_length(11'd0);
    send_word(31'h5555_5555);
    send_word(31'd7);
  endtask

  // full round by collisions, sender paused until all results are back
  task automatic test_small_round();
    write_length(11'd3);
    send_word(31'd5);
    send_word(31'd5);
    drain_results();
    send_word(31'd5);
    send_word(31'd2);
  endtask

  // lengths above the maximum clamp to it
  task automatic test_length_over();
    write_length(11'd2047);
    send_word(31'h7fff_ffff);
    send_word(31'd3071);
    write_length(11'd1025);
    send_word(31'h7fff_fbff);
  endtask

  // rewrite mid-round abandons the round
  task automatic test_abandon();
    write_length(11'd5);
    send_word(31'd4);
    send_word(31'd9);
    write_length(11'd5);
    send_word(31'd4);
    send_word(31'd9);
  endtask

  task automatic test_random();
    int unsigned first, sel, n, cnt, k;
    logic [LEN_W-1:0] len;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel < 11) len = LEN_W'($urandom_range(1, 16));
      else if (sel < 16) len = LEN_W'($urandom_range(17, 200));
      else if (sel < 18) len = LEN_W'($urandom_range(201, 1024));
      else if (sel == 18) len = '0;
      else len = LEN_W'($urandom_range(1025, 2047));
      write_length(len);
      n = round_len(len);
      no_idle = ($urandom_range(0, 3) == 0);
      if (n <= 200 && $urandom_range(0, 3) != 0)
        cnt = n * $urandom_range(1, 2) + $urandom_range(0, n / 2);
      else
        cnt = $urandom_range(1, 40);
      for (k = 0; k < cnt && items_sent - first < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 49) == 0) drain_results();
        send_word(pick_word(n));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_check
    slot_result_t want;
    int unsigned hold;
    hold = 0;
    slot_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && slot_bus.valid && slot_bus.ready) begin
        if (pending_slots.size() == 0) begin
          report_mismatch($sformatf("unexpected item slot=%0d last=%0b",
                                    slot_bus.slot_number, slot_bus.last_of_round));
        end else begin
          want = pending_slots.pop_front();
          if (slot_bus.slot_number !== want.slot_number)
            report_mismatch($sformatf("slot_number got %0d want %0d",
                                      slot_bus.slot_number, want.slot_number));
          if (slot_bus.last_of_round !== want.last_of_round)
            report_mismatch($sformatf("last_of_round got %0b want %0b (slot %0d)",
                                      slot_bus.last_of_round, want.last_of_round,
                                      want.slot_number));
        end
        hold = draw_gap();
      end else if (hold > 0) begin
        hold--;
      end
      slot_bus.ready <= (hold == 0);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: timeout, %0d items still expected", pending_slots.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    errors     = 0;
    items_sent = 0;
    no_idle    = 1'b0;
    word_held  = 1'b0;
    prev_word  = '0;
    length_reg = LEN_RESET;
    round_fill = 0;
    word_bus.valid       <= 1'b0;
    word_bus.random_word <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_length();
    test_length_one();
    test_small_round();
    test_length_over();
    test_abandon();
    test_random();

    drain_results();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
